// ===== hw/rtl/vau_pkg.sv =====
// Shared types, operation codes and saturation helper for the vector ALU.
package vau_pkg;

    // Word format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    // Shifted numerator / quotient width of the divider
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    // Sum of squares width and square-root remainder width
    localparam int RAD_BITS  = 2 * WORD_BITS;
    localparam int REM_BITS  = WORD_BITS + 3;
    // Wide signed width used ahead of saturation
    localparam int WIDE_BITS = 2 * WORD_BITS + 2;

    // Operation codes
    localparam logic [3:0] OP_ADD       = 4'd0;
    localparam logic [3:0] OP_SUB       = 4'd1;
    localparam logic [3:0] OP_MUL       = 4'd2;
    localparam logic [3:0] OP_DIV       = 4'd3;
    localparam logic [3:0] OP_DOT       = 4'd4;
    localparam logic [3:0] OP_CROSS     = 4'd5;
    localparam logic [3:0] OP_LENGTH    = 4'd6;
    localparam logic [3:0] OP_NORMALIZE = 4'd7;
    localparam logic [3:0] OP_EQUAL     = 4'd8;

    // Saturation bounds in the wide format
    localparam logic signed [WIDE_BITS-1:0] WORD_HI =
        $signed({{(WIDE_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
    localparam logic signed [WIDE_BITS-1:0] WORD_LO = ~WORD_HI;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic [3:0] operation;
        t_word      a_x;
        t_word      a_y;
        t_word      a_z;
        t_word      b_x;
        t_word      b_y;
        t_word      b_z;
    } t_in_item;

    typedef struct packed {
        t_word r_x;
        t_word r_y;
        t_word r_z;
        logic  is_equal;
        logic  zero_divisor;
        logic  saturated;
    } t_out_item;

    // Item context carried down the whole pipeline
    typedef struct packed {
        logic [3:0]  op;
        t_word [2:0] res;
        logic        sat;
        logic        eq;
        t_word [2:0] a;
        t_word [2:0] b;
        t_word       len;
    } t_side;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_clamp;

    // Clamp a wide signed value to the word range
    function automatic t_clamp clamp_word(input logic signed [WIDE_BITS-1:0] v);
        t_clamp c;
        c.sat = 1'b0;
        c.val = v[WORD_BITS-1:0];
        if (v > WORD_HI) begin
            c.sat = 1'b1;
            c.val = WORD_HI[WORD_BITS-1:0];
        end else if (v < WORD_LO) begin
            c.sat = 1'b1;
            c.val = WORD_LO[WORD_BITS-1:0];
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/vau_front.sv =====
// Front end: product stage, then combine and saturate stage for the simple operations.
module vau_front import vau_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_in_item            i_item,
    output logic                o_valid,
    output t_side               o_side,
    output logic [RAD_BITS-1:0] o_rad
);

    logic [2:0][WORD_BITS-1:0]       w_a;
    logic [2:0][WORD_BITS-1:0]       w_b;
    logic signed [WORD_BITS-1:0]     w_ml [6];
    logic signed [WORD_BITS-1:0]     w_mr [6];

    logic                            r_v1;
    logic [3:0]                      r_op;
    logic [2:0][WORD_BITS-1:0]       r_a;
    logic [2:0][WORD_BITS-1:0]       r_b;
    logic signed [RAD_BITS-1:0]      r_p [6];

    logic signed [WIDE_BITS-1:0]     w_f [6];
    logic signed [WIDE_BITS-1:0]     w_pre [3];
    t_clamp                          w_cl [3];
    t_side                           n_side;
    logic [RAD_BITS-1:0]             n_rad;

    logic                            r_v2;
    t_side                           r_side;
    logic [RAD_BITS-1:0]             r_rad;

    assign w_a = {i_item.a_z, i_item.a_y, i_item.a_x};
    assign w_b = {i_item.b_z, i_item.b_y, i_item.b_x};

    // Route multiplier operands by operation
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_ml[k] = '0;
            w_mr[k] = '0;
        end
        case (i_item.operation)
            OP_CROSS: begin
                w_ml[0] = w_a[1]; w_mr[0] = w_b[2];
                w_ml[1] = w_a[2]; w_mr[1] = w_b[1];
                w_ml[2] = w_a[2]; w_mr[2] = w_b[0];
                w_ml[3] = w_a[0]; w_mr[3] = w_b[2];
                w_ml[4] = w_a[0]; w_mr[4] = w_b[1];
                w_ml[5] = w_a[1]; w_mr[5] = w_b[0];
            end
            OP_LENGTH, OP_NORMALIZE: begin
                for (int k = 0; k < 3; k++) begin
                    w_ml[k] = w_a[k];
                    w_mr[k] = w_a[k];
                end
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    w_ml[k] = w_a[k];
                    w_mr[k] = w_b[k];
                end
            end
        endcase
    end

    // Stage one: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op <= i_item.operation;
            r_a  <= w_a;
            r_b  <= w_b;
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= w_ml[k] * w_mr[k];
            end
        end
    end

    // Floor-shift products back to the fixed-point scale
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_f[k] = WIDE_BITS'(r_p[k] >>> FRAC_BITS);
        end
    end

    // Stage two: combine, compare and saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pre[k] = '0;
        end
        n_side     = '0;
        n_side.op  = r_op;
        n_side.a   = r_a;
        n_side.b   = r_b;
        n_side.eq  = 1'b0;
        case (r_op)
            OP_ADD: begin
                for (int k = 0; k < 3; k++) begin
                    w_pre[k] = WIDE_BITS'($signed(r_a[k])) + WIDE_BITS'($signed(r_b[k]));
                end
            end
            OP_SUB: begin
                for (int k = 0; k < 3; k++) begin
                    w_pre[k] = WIDE_BITS'($signed(r_a[k])) - WIDE_BITS'($signed(r_b[k]));
                end
            end
            OP_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    w_pre[k] = w_f[k];
                end
            end
            OP_DOT: begin
                w_pre[0] = w_f[0] + w_f[1] + w_f[2];
            end
            OP_CROSS: begin
                w_pre[0] = w_f[0] - w_f[1];
                w_pre[1] = w_f[2] - w_f[3];
                w_pre[2] = w_f[4] - w_f[5];
            end
            OP_EQUAL: begin
                n_side.eq = (r_a == r_b);
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            w_cl[k]       = clamp_word(w_pre[k]);
            n_side.res[k] = w_cl[k].val;
        end
        n_side.sat = w_cl[0].sat | w_cl[1].sat | w_cl[2].sat;
        // Sum of squares fits the unsigned radicand
        n_rad = $unsigned(r_p[0]) + $unsigned(r_p[1]) + $unsigned(r_p[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_rad  <= n_rad;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side;
    assign o_rad   = r_rad;

endmodule

// ===== hw/rtl/vau_sqrt_step.sv =====
// One registered step of the integer square root: two radicand bits, one root bit.
module vau_sqrt_step import vau_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RAD_BITS-1:0]  i_rad,
    input  logic [REM_BITS-1:0]  i_rem,
    input  logic [WORD_BITS-1:0] i_root,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [RAD_BITS-1:0]  o_rad,
    output logic [REM_BITS-1:0]  o_rem,
    output logic [WORD_BITS-1:0] o_root,
    output t_side                o_side
);

    logic [REM_BITS-1:0]  w_cat;
    logic [REM_BITS-1:0]  w_trial;
    logic                 w_ge;
    logic [REM_BITS-1:0]  n_rem;
    logic [WORD_BITS-1:0] n_root;
    logic [RAD_BITS-1:0]  n_rad;

    logic                 r_valid;
    logic [RAD_BITS-1:0]  r_rad;
    logic [REM_BITS-1:0]  r_rem;
    logic [WORD_BITS-1:0] r_root;
    t_side                r_side;

    // Bring down two bits and try the next root bit
    always_comb begin
        w_cat   = {i_rem[WORD_BITS:0], i_rad[RAD_BITS-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_ge    = (w_cat >= w_trial);
        n_rem   = w_ge ? (w_cat - w_trial) : w_cat;
        n_root  = {i_root[WORD_BITS-2:0], w_ge};
        n_rad   = {i_rad[RAD_BITS-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

// ===== hw/rtl/vau_div_step.sv =====
// One registered restoring-division step for all three lanes: one quotient bit each.
module vau_div_step import vau_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [2:0][WORD_BITS-1:0] i_d,
    input  logic [2:0][NUM_BITS-1:0]  i_nq,
    input  logic [2:0][WORD_BITS-1:0] i_rem,
    input  t_side                     i_side,
    output logic                      o_valid,
    output logic [2:0][WORD_BITS-1:0] o_d,
    output logic [2:0][NUM_BITS-1:0]  o_nq,
    output logic [2:0][WORD_BITS-1:0] o_rem,
    output t_side                     o_side
);

    logic [WORD_BITS:0]            w_cat [3];
    logic [WORD_BITS:0]            w_diff [3];
    logic [2:0]                    w_ge;
    logic [2:0][NUM_BITS-1:0]      n_nq;
    logic [2:0][WORD_BITS-1:0]     n_rem;

    logic                          r_valid;
    logic [2:0][WORD_BITS-1:0]     r_d;
    logic [2:0][NUM_BITS-1:0]      r_nq;
    logic [2:0][WORD_BITS-1:0]     r_rem;
    t_side                         r_side;

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cat[k]  = {i_rem[k], i_nq[k][NUM_BITS-1]};
            w_diff[k] = w_cat[k] - {1'b0, i_d[k]};
            w_ge[k]   = (w_cat[k] >= {1'b0, i_d[k]});
            n_rem[k]  = w_ge[k] ? w_diff[k][WORD_BITS-1:0] : w_cat[k][WORD_BITS-1:0];
            n_nq[k]   = {i_nq[k][NUM_BITS-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= i_d;
            r_nq   <= n_nq;
            r_rem  <= n_rem;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_nq    = r_nq;
    assign o_rem   = r_rem;
    assign o_side  = r_side;

endmodule

// ===== hw/rtl/vec3_arithmetic_unit.sv =====
// Top level of the pipelined three-component Q16.16 vector ALU.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+----------------------------
//   input   | i_in_valid | o_in_ready  | i_in  (t_in_item)
//   output  | o_out_valid| i_out_ready | o_out (t_out_item)
//
// One item enters per cycle while o_in_ready is high; every item passes through
// 2 front stages, 32 square-root steps, 1 divider setup stage, 48 divider
// steps and the output register. The divider bit count sets the depth.
// Synchronous active-low reset clears all stage valid bits.
// The whole pipeline holds when the output register is full and not taken.
module vec3_arithmetic_unit import vau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int SQRT_STEPS = WORD_BITS;
    localparam int DIV_STEPS  = NUM_BITS;

    logic                      w_en;

    logic                      w_sq_v    [SQRT_STEPS+1];
    logic [RAD_BITS-1:0]       w_sq_rad  [SQRT_STEPS+1];
    logic [REM_BITS-1:0]       w_sq_rem  [SQRT_STEPS+1];
    logic [WORD_BITS-1:0]      w_sq_root [SQRT_STEPS+1];
    t_side                     w_sq_side [SQRT_STEPS+1];

    t_side                     n_su_side;
    logic [2:0][WORD_BITS-1:0] n_su_d;
    logic [2:0][NUM_BITS-1:0]  n_su_nq;
    logic [WORD_BITS-1:0]      w_mag_a [3];
    logic [WORD_BITS-1:0]      w_mag_b [3];

    logic                      r_su_v;
    t_side                     r_su_side;
    logic [2:0][WORD_BITS-1:0] r_su_d;
    logic [2:0][NUM_BITS-1:0]  r_su_nq;

    logic                      w_dv_v    [DIV_STEPS+1];
    logic [2:0][WORD_BITS-1:0] w_dv_d    [DIV_STEPS+1];
    logic [2:0][NUM_BITS-1:0]  w_dv_nq   [DIV_STEPS+1];
    logic [2:0][WORD_BITS-1:0] w_dv_rem  [DIV_STEPS+1];
    t_side                     w_dv_side [DIV_STEPS+1];

    t_side                     w_fs;
    logic                      w_neg [3];
    logic signed [WIDE_BITS-1:0] w_q [3];
    t_clamp                    w_qc [3];
    t_clamp                    w_lc;
    logic [2:0][WORD_BITS-1:0] n_res;
    logic                      n_sat;
    logic                      n_zdiv;
    t_out_item                 n_out;

    logic                      r_out_v;
    t_out_item                 r_out;
    logic [3:0]                r_out_op;

    // Advance every stage whenever the output register can move
    assign w_en       = !r_out_v || i_out_ready;
    assign o_in_ready = w_en;

    vau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in),
        .o_valid (w_sq_v[0]),
        .o_side  (w_sq_side[0]),
        .o_rad   (w_sq_rad[0])
    );

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;

    // Square-root chain
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        vau_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_rad   (w_sq_rad[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_v[g+1]),
            .o_rad   (w_sq_rad[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    // Divider setup: magnitudes, scaled numerators and divisor choice
    always_comb begin
        n_su_side     = w_sq_side[SQRT_STEPS];
        n_su_side.len = w_sq_root[SQRT_STEPS];
        for (int k = 0; k < 3; k++) begin
            w_mag_a[k] = n_su_side.a[k][WORD_BITS-1] ? (~n_su_side.a[k] + 1'b1)
                                                     : n_su_side.a[k];
            w_mag_b[k] = n_su_side.b[k][WORD_BITS-1] ? (~n_su_side.b[k] + 1'b1)
                                                     : n_su_side.b[k];
            n_su_nq[k] = {w_mag_a[k], {FRAC_BITS{1'b0}}};
            n_su_d[k]  = (n_su_side.op == OP_NORMALIZE) ? n_su_side.len : w_mag_b[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su_v <= 1'b0;
        end else if (w_en) begin
            r_su_v <= w_sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_su_side <= n_su_side;
            r_su_d    <= n_su_d;
            r_su_nq   <= n_su_nq;
        end
    end

    assign w_dv_v[0]    = r_su_v;
    assign w_dv_d[0]    = r_su_d;
    assign w_dv_nq[0]   = r_su_nq;
    assign w_dv_rem[0]  = '0;
    assign w_dv_side[0] = r_su_side;

    // Divider chain
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        vau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[g]),
            .i_d     (w_dv_d[g]),
            .i_nq    (w_dv_nq[g]),
            .i_rem   (w_dv_rem[g]),
            .i_side  (w_dv_side[g]),
            .o_valid (w_dv_v[g+1]),
            .o_d     (w_dv_d[g+1]),
            .o_nq    (w_dv_nq[g+1]),
            .o_rem   (w_dv_rem[g+1]),
            .o_side  (w_dv_side[g+1])
        );
    end

    // Sign the quotients, saturate, and pick the result per operation
    always_comb begin
        w_fs   = w_dv_side[DIV_STEPS];
        n_res  = w_fs.res;
        n_sat  = w_fs.sat;
        n_zdiv = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_neg[k] = w_fs.a[k][WORD_BITS-1] ^
                       ((w_fs.op == OP_DIV) && w_fs.b[k][WORD_BITS-1]);
            w_q[k]   = $signed(WIDE_BITS'(w_dv_nq[DIV_STEPS][k]));
            if (w_neg[k]) begin
                w_q[k] = -w_q[k];
            end
            w_qc[k]  = clamp_word(w_q[k]);
        end
        w_lc = clamp_word($signed(WIDE_BITS'(w_fs.len)));
        case (w_fs.op)
            OP_DIV: begin
                n_sat = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    if (w_fs.b[k] == '0) begin
                        n_zdiv = 1'b1;
                        if (w_fs.a[k] == '0) begin
                            n_res[k] = '0;
                        end else if (w_fs.a[k][WORD_BITS-1]) begin
                            n_res[k] = WORD_LO[WORD_BITS-1:0];
                            n_sat    = 1'b1;
                        end else begin
                            n_res[k] = WORD_HI[WORD_BITS-1:0];
                            n_sat    = 1'b1;
                        end
                    end else begin
                        n_res[k] = w_qc[k].val;
                        n_sat    = n_sat | w_qc[k].sat;
                    end
                end
            end
            OP_NORMALIZE: begin
                n_sat = 1'b0;
                if (w_fs.len == '0) begin
                    n_zdiv = 1'b1;
                    n_res  = '0;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        n_res[k] = w_qc[k].val;
                        n_sat    = n_sat | w_qc[k].sat;
                    end
                end
            end
            OP_LENGTH: begin
                n_res    = '0;
                n_res[0] = w_lc.val;
                n_sat    = w_lc.sat;
            end
            default: begin
            end
        endcase
        n_out.r_x          = n_res[0];
        n_out.r_y          = n_res[1];
        n_out.r_z          = n_res[2];
        n_out.is_equal     = w_fs.eq;
        n_out.zero_divisor = n_zdiv;
        n_out.saturated    = n_sat;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out    <= n_out;
            r_out_op <= w_fs.op;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_eq_only_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_equal |-> r_out_op == OP_EQUAL)
        else $error("is_equal set on a non-equal operation");

    a_scalar_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_out_op == OP_DOT || r_out_op == OP_LENGTH ||
                        r_out_op == OP_EQUAL)
        |-> o_out.r_y == '0 && o_out.r_z == '0)
        else $error("scalar result with nonzero y or z lane");

    a_zdiv_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.zero_divisor
        |-> r_out_op == OP_DIV || r_out_op == OP_NORMALIZE)
        else $error("zero_divisor set on an operation without division");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_su_v) && $stable(r_su_d))
        else $error("divider setup stage moved during a stall");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pipelined three-component vector ALU.
`timescale 1ns / 100ps

module tb_top;
    import vau_pkg::*;

    localparam int LATENCY   = 84;
    localparam int N_RANDOM  = 1080;
    localparam int N_QUIET   = 150;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];

    int  sent_count;
    int  checked_count;
    int  mismatch_count;
    int  op_count[16];
    bit  quiet_phase;
    bit  stimulus_done;
    int  src_idle;
    int  sink_idle;
    int  hold_off;
    bit  hold_done;

    vec3_arithmetic_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clamp a wide value to the signed word range
    function automatic logic signed [127:0] sat_word(input logic signed [127:0] v,
                                                     inout bit sat);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = 128'sd2147483647;
        lo = -128'sd2147483648;
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Fixed-point product, floor of the shifted exact product
    function automatic logic signed [127:0] fx_product(input logic signed [127:0] x,
                                                       input logic signed [127:0] y);
        logic signed [127:0] p;
        p = x * y;
        return p >>> FRAC_BITS;
    endfunction

    // Fixed-point quotient, truncated toward zero
    function automatic logic signed [127:0] fx_quotient(input logic signed [127:0] n,
                                                        input logic signed [127:0] d);
        logic signed [127:0] num;
        num = n * 128'sd65536;
        return num / d;
    endfunction

    // Floor square root of a nonnegative value
    function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
        logic [127:0] root;
        logic [127:0] bitv;
        root = 0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Compute the expected result vector and flags of one item
    function automatic t_out_item vector_alu_result(input t_in_item it);
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] r[3];
        logic [127:0]        len;
        bit                  sat;
        bit                  zdiv;
        bit                  eq;
        t_out_item           res;
        a[0] = $signed(it.a_x); a[1] = $signed(it.a_y); a[2] = $signed(it.a_z);
        b[0] = $signed(it.b_x); b[1] = $signed(it.b_y); b[2] = $signed(it.b_z);
        r[0] = 0; r[1] = 0; r[2] = 0;
        sat = 0; zdiv = 0; eq = 0;
        case (it.operation)
            OP_ADD: for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] + b[i], sat);
            OP_SUB: for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] - b[i], sat);
            OP_MUL: for (int i = 0; i < 3; i++) r[i] = sat_word(fx_product(a[i], b[i]), sat);
            OP_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (b[i] == 0) begin
                        zdiv = 1'b1;
                        if (a[i] > 0) r[i] = sat_word(128'sd1 <<< 100, sat);
                        else if (a[i] < 0) r[i] = sat_word(-(128'sd1 <<< 100), sat);
                    end else begin
                        r[i] = sat_word(fx_quotient(a[i], b[i]), sat);
                    end
                end
            end
            OP_DOT: r[0] = sat_word(fx_product(a[0], b[0]) + fx_product(a[1], b[1])
                                    + fx_product(a[2], b[2]), sat);
            OP_CROSS: begin
                r[0] = sat_word(fx_product(a[1], b[2]) - fx_product(a[2], b[1]), sat);
                r[1] = sat_word(fx_product(a[2], b[0]) - fx_product(a[0], b[2]), sat);
                r[2] = sat_word(fx_product(a[0], b[1]) - fx_product(a[1], b[0]), sat);
            end
            OP_LENGTH, OP_NORMALIZE: begin
                len = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                if (it.operation == OP_LENGTH) begin
                    r[0] = sat_word($signed(len), sat);
                end else if (len == 0) begin
                    zdiv = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++)
                        r[i] = sat_word(fx_quotient(a[i], $signed(len)), sat);
                end
            end
            OP_EQUAL: eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            default: ;
        endcase
        res.r_x          = r[0][31:0];
        res.r_y          = r[1][31:0];
        res.r_z          = r[2][31:0];
        res.is_equal     = eq;
        res.zero_divisor = zdiv;
        res.saturated    = sat;
        return res;
    endfunction

    // Random word, biased toward extremes and small magnitudes
    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return t_word'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
            4, 5: return t_word'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [3:0] op, input t_word ax,
                                           input t_word ay, input t_word az,
                                           input t_word bx, input t_word by,
                                           input t_word bz);
        t_in_item it;
        it.operation = op;
        it.a_x = ax; it.a_y = ay; it.a_z = az;
        it.b_x = bx; it.b_y = by; it.b_z = bz;
        return it;
    endfunction

    // Fill the stimulus queue: directed corners first, then random items
    initial begin
        t_in_item it;
        t_word    mx;
        t_word    mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        pending_items.push_back(make_item(OP_ADD, mx, mn, 1, 1, mn, 0));
        pending_items.push_back(make_item(OP_SUB, mn, mx, 0, 1, mn, mx));
        pending_items.push_back(make_item(OP_MUL, mx, mn, mn, mx, mn, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(OP_MUL, 32'h0001_8000, 32'hFFFF_FFFF, 3,
                                          32'h0002_0000, 1, 32'hFFFF_0000));
        pending_items.push_back(make_item(OP_DIV, 5, mn, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_DIV, mx, mn, 32'h0003_0000,
                                          1, 32'hFFFF_FFFF, 32'hFFFE_0000));
        pending_items.push_back(make_item(OP_DOT, mx, mx, mx, mx, mx, mx));
        pending_items.push_back(make_item(OP_DOT, mn, mn, mn, mx, mx, mx));
        pending_items.push_back(make_item(OP_CROSS, mx, mn, mx, mn, mx, mn));
        pending_items.push_back(make_item(OP_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0));
        pending_items.push_back(make_item(OP_LENGTH, mn, mn, mn, 0, 0, 0));
        pending_items.push_back(make_item(OP_LENGTH, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_NORMALIZE, 0, 0, 0, 1, 2, 3));
        pending_items.push_back(make_item(OP_NORMALIZE, 1, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_NORMALIZE, mn, mx, 1, 0, 0, 0));
        pending_items.push_back(make_item(OP_EQUAL, mn, mx, 7, mn, mx, 7));
        pending_items.push_back(make_item(OP_EQUAL, mn, mx, 7, mn, mx, 6));
        pending_items.push_back(make_item(4'd9, mx, mx, mx, mx, mx, mx));
        pending_items.push_back(make_item(4'd15, mn, mn, mn, 0, 0, 0));
        for (int n = 0; n < N_RANDOM; n++) begin
            it.operation = (n % 20 == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
            it.a_x = rand_word(); it.a_y = rand_word(); it.a_z = rand_word();
            it.b_x = rand_word(); it.b_y = rand_word(); it.b_z = rand_word();
            // Make equality and zero divisors show up often
            if (it.operation == OP_EQUAL && $urandom_range(0, 1)) begin
                it.b_x = it.a_x; it.b_y = it.a_y;
                it.b_z = $urandom_range(0, 1) ? it.a_z
                                              : it.a_z ^ (32'd1 << $urandom_range(0, 31));
            end
            if (it.operation == OP_DIV && $urandom_range(0, 3) == 0) it.b_y = 0;
            if (it.operation == OP_NORMALIZE && $urandom_range(0, 9) == 0) begin
                it.a_x = 0; it.a_y = 0; it.a_z = 0;
            end
            pending_items.push_back(it);
        end
    end

    // Reset
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: present items, hold them until accepted, idle in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in       <= '0;
            src_idle   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                expected_results.push_back(vector_alu_result(i_in));
                op_count[i_in.operation]++;
                sent_count++;
            end
            if (src_idle > 0) begin
                src_idle   <= src_idle - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in       <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 15) == 0)
                    src_idle <= $urandom_range(1, 7);
            end else begin
                i_in_valid <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    assign quiet_phase = (pending_items.size() < N_QUIET);

    // Long hold-off once, to back the pipeline up into the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && sent_count == 300) begin
            hold_done <= 1'b1;
            hold_off  <= 3 * LATENCY;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_idle   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h at %0t", o_out, $time);
                end else begin
                    exp_item = expected_results.pop_front();
                    checked_count++;
                    if (o_out !== exp_item) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch #%0d: exp x=%h y=%h z=%h eq=%b zd=%b sat=%b",
                                     checked_count, exp_item.r_x, exp_item.r_y,
                                     exp_item.r_z, exp_item.is_equal,
                                     exp_item.zero_divisor, exp_item.saturated);
                            $display("    got x=%h y=%h z=%h eq=%b zd=%b sat=%b",
                                     o_out.r_x, o_out.r_y, o_out.r_z,
                                     o_out.is_equal, o_out.zero_divisor, o_out.saturated);
                        end
                    end
                end
            end
            // Hold off during the long stretch, else idle in random bursts
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
            end else if (sink_idle > 0) begin
                sink_idle   <= sink_idle - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 11) == 0)
                    sink_idle <= $urandom_range(1, 7);
            end
        end
    end

    // Wait for the queue to drain, then report
    initial begin
        stimulus_done = 1'b0;
        sent_count = 0;
        checked_count = 0;
        mismatch_count = 0;
        foreach (op_count[k]) op_count[k] = 0;
        wait (stimulus_done && expected_results.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("checked %0d results; add %0d sub %0d mul %0d div %0d dot %0d",
                 checked_count, op_count[0], op_count[1], op_count[2],
                 op_count[3], op_count[4]);
        $display("cross %0d length %0d normalize %0d equal %0d, unused codes and a long stall too",
                 op_count[5], op_count[6], op_count[7], op_count[8]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vau_pkg.sv
hw/rtl/vau_front.sv
hw/rtl/vau_sqrt_step.sv
hw/rtl/vau_div_step.sv
hw/rtl/vec3_arithmetic_unit.sv
tb/tb_top.sv
